// ===== sv/mfhd_pkg.sv =====
`default_nettype none
package mfhd_pkg;

  // Bytes that make up one frame header, counted from the sync byte.
  localparam int unsigned HEADER_BYTES = 10;
  // Width of the byte position and frame length (frames of up to 2047 bytes).
  localparam int unsigned POS_W = 11;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] LAYER_MASK = 8'hF6;
  localparam logic [7:0] LAYER_VAL  = 8'hF4;

  localparam logic [3:0] BIDX_FREE = 4'd0;
  localparam logic [3:0] BIDX_BAD  = 4'd15;

  localparam logic [1:0] RIDX_44K = 2'd0;  // 44100 / 22050
  localparam logic [1:0] RIDX_48K = 2'd1;  // 48000 / 24000
  localparam logic [1:0] RIDX_32K = 2'd2;  // 32000 / 16000

  // ceil(2^22 / 49): floor(x / 49) = (x * RECIP_49) >> 22 for x below 89240
  localparam logic [16:0] RECIP_49 = 17'd85599;
  localparam int unsigned RECIP_SH = 22;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SYNC    = 2'd1,
    ST_BITRATE = 2'd2,
    ST_RATE    = 2'd3
  } status_e;

  localparam logic [8:0] KBPS_M1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0
  };
  localparam logic [8:0] KBPS_M2 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
  };

  // Decoded header, without the frame count.
  typedef struct packed {
    status_e     status;
    logic [10:0] frame_bytes;
    logic        is_mpeg2;
    logic        padding;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
  } dec_t;

  // One result as delivered on the output channel.
  typedef struct packed {
    status_e     status;
    logic [31:0] frame_number;
    logic [10:0] frame_bytes;
    logic        is_mpeg2;
    logic        padding;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/mfhd_decode.sv =====
`default_nettype none
module mfhd_decode
  import mfhd_pkg::*;
(
  input  logic [7:0] h0_i,
  input  logic [7:0] h1_i,
  input  logic [7:0] h2_i,
  output dec_t       dec_o
);

  logic [3:0]  bidx;
  logic [1:0]  ridx;
  logic        pad;
  logic        m2;
  logic [8:0]  kbps;
  logic [15:0] hz;
  logic [15:0] x160;
  logic [15:0] x;
  logic [32:0] prod;
  logic [10:0] k3;
  logic [11:0] k9;
  logic [10:0] base;

  always_comb begin
    bidx = h2_i[7:4];
    ridx = h2_i[3:2];
    pad  = h2_i[1];
    m2   = ~h1_i[3];
    kbps = m2 ? KBPS_M2[bidx] : KBPS_M1[bidx];

    // 44.1 kHz family: 160*kbps/49 (MPEG-1) or 320*kbps/49 (MPEG-2)
    x160 = 16'({kbps, 7'b0}) + 16'({kbps, 5'b0});
    x    = m2 ? {x160[14:0], 1'b0} : x160;
    prod = 33'(x) * 33'(RECIP_49);

    k3 = 11'({kbps, 1'b0}) + 11'(kbps);
    k9 = 12'({kbps, 3'b0}) + 12'(kbps);

    unique case (ridx)
      RIDX_44K: begin
        base = prod[RECIP_SH +: 11];
        hz   = m2 ? 16'd22050 : 16'd44100;
      end
      RIDX_48K: begin
        base = m2 ? {k3[9:0], 1'b0} : k3;
        hz   = m2 ? 16'd24000 : 16'd48000;
      end
      RIDX_32K: begin
        base = m2 ? k9[10:0] : k9[11:1];
        hz   = m2 ? 16'd16000 : 16'd32000;
      end
      default: begin
        base = '0;
        hz   = '0;
      end
    endcase

    dec_o = '0;
    priority if (h0_i != SYNC_BYTE || (h1_i & LAYER_MASK) != LAYER_VAL) begin
      dec_o.status = ST_SYNC;
    end else if (bidx == BIDX_FREE || bidx == BIDX_BAD) begin
      dec_o.status = ST_BITRATE;
    end else if (ridx != RIDX_44K && ridx != RIDX_48K && ridx != RIDX_32K) begin
      dec_o.status = ST_RATE;
    end else begin
      dec_o.status         = ST_OK;
      dec_o.frame_bytes    = base + 11'(pad);
      dec_o.is_mpeg2       = m2;
      dec_o.padding        = pad;
      dec_o.bitrate_kbps   = kbps;
      dec_o.sample_rate_hz = hz;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mfhd_outbuf.sv =====
`default_nettype none
module mfhd_outbuf
  import mfhd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic main_v_q;
  logic skid_v_q;
  res_t main_q;
  res_t skid_q;
  logic pop;

  assign pop         = main_v_q & out_ready_i;
  assign ready_o     = ~skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop || !main_v_q) begin
      // Advance: skid first, else the fresh request.
      if (skid_v_q) begin
        main_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !main_v_q) begin
      main_q <= skid_v_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mp2_frame_header_deframer_unit.sv =====
`default_nettype none
// MPEG audio Layer II frame header deframer. Feed the compressed stream one
// byte per request on the input channel; the block takes a byte in every
// cycle but for the stall below. The first HEADER_BYTES (10) bytes of a
// frame are its header: at the last of them the block checks sync, layer,
// bitrate index and sample-rate index and emits one result (status, running
// count of good headers, frame length in bytes, MPEG-2 flag, padding,
// bitrate and sample rate). The rest of a good frame is skipped without
// results; after a bad header the hunt restarts at the very next byte. A
// byte passes an input register before it is handled. The frame length is
// a table lookup plus, for the 44.1 kHz family, one multiply by a
// reciprocal of 49, done combinationally. Results leave through a two-entry
// output buffer; the input stalls only while both entries hold results
// that have not been taken.
module mp2_frame_header_deframer_unit
  import mfhd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] frame_number_o,
  output logic [10:0] frame_bytes_o,
  output logic        is_mpeg2_o,
  output logic        padding_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o
);

  // Input register.
  logic       byte_v_q;
  logic [7:0] byte_q;

  // Deframing state.
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] len_q, len_d;
  logic [31:0]      cnt_q, cnt_d;
  logic [7:0]       hdr_q [3];

  logic             buf_ready;
  logic             step;
  logic             push;
  logic [POS_W:0]   pos_inc;
  dec_t             dec;
  res_t             res;
  res_t             out_res;

  assign in_ready_o = ~byte_v_q | buf_ready;
  assign step       = byte_v_q & buf_ready;
  assign pos_inc    = {1'b0, pos_q} + 1'b1;

  mfhd_decode u_decode (
    .h0_i  (hdr_q[0]),
    .h1_i  (hdr_q[1]),
    .h2_i  (hdr_q[2]),
    .dec_o (dec)
  );

  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    cnt_d = cnt_q;
    push  = 1'b0;

    res.status         = dec.status;
    res.frame_number   = cnt_q;
    res.frame_bytes    = dec.frame_bytes;
    res.is_mpeg2       = dec.is_mpeg2;
    res.padding        = dec.padding;
    res.bitrate_kbps   = dec.bitrate_kbps;
    res.sample_rate_hz = dec.sample_rate_hz;

    if (step) begin
      priority if ({1'b0, pos_q} >= (POS_W + 1)'(HEADER_BYTES)) begin
        // Skip the frame body, wrap to the next header at its end.
        pos_d = (pos_inc >= {1'b0, len_q}) ? '0 : pos_inc[POS_W-1:0];
      end else if (pos_inc < (POS_W + 1)'(HEADER_BYTES)) begin
        pos_d = pos_inc[POS_W-1:0];
      end else begin
        push = 1'b1;
        if (dec.status == ST_OK) begin
          cnt_d            = cnt_q + 32'd1;
          res.frame_number = cnt_d;
          len_d            = dec.frame_bytes;
          pos_d = (dec.frame_bytes <= POS_W'(HEADER_BYTES)) ? '0
                                                             : POS_W'(HEADER_BYTES);
        end else begin
          // Hunt again from the next byte.
          pos_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_v_q <= 1'b0;
      pos_q    <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_ready_o) begin
        byte_v_q <= in_valid_i;
      end
      pos_q <= pos_d;
      len_q <= len_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload: byte register and the header bytes that the check reads.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
    if (step && pos_q < POS_W'(3)) begin
      hdr_q[pos_q[1:0]] <= byte_q;
    end
  end

  mfhd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign status_o         = out_res.status;
  assign frame_number_o   = out_res.frame_number;
  assign frame_bytes_o    = out_res.frame_bytes;
  assign is_mpeg2_o       = out_res.is_mpeg2;
  assign padding_o        = out_res.padding;
  assign bitrate_kbps_o   = out_res.bitrate_kbps;
  assign sample_rate_hz_o = out_res.sample_rate_hz;

  // Body skipping only happens for frames longer than the header.
  a_skip_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pos_q} >= (POS_W + 1)'(HEADER_BYTES)) |-> (len_q > POS_W'(HEADER_BYTES)))
    else $error("skipping a frame body with a short frame length");

  // A good header bumps the frame count by exactly one.
  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.status == ST_OK) |=> (cnt_q == $past(cnt_q) + 32'd1))
    else $error("frame count did not advance on a good header");

  // No count change without a good header result.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && res.status == ST_OK) |=> (cnt_q == $past(cnt_q)))
    else $error("frame count changed without a good header");

  // The input stalls only while results are waiting at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule
`default_nettype wire
